### rtl/fbt3_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fbt3_pkg - shared types and constants
// widths, operation codes, sequencer states and the walk step record
// ---------------------------------------------------------------------------
package fbt3_pkg;

    // coordinate width: six input bits plus one carry bit for the upward walk
    localparam int CW           = 7;
    localparam int IN_CW        = 6;
    localparam int VAL_W        = 32;
    localparam int SUM_W        = 64;
    localparam int SIDE_DEFAULT = 32;
    localparam logic [IN_CW-1:0] SIDE_RESET = 6'd32;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET_RD,
        ST_SET_DELTA,
        ST_PFX_START,
        ST_NODE_RD,
        ST_NODE_UPD,
        ST_FINISH
    } state_t;

    // one step of the three-axis tree walk
    typedef struct packed {
        logic [CW-1:0] i;
        logic [CW-1:0] j;
        logic [CW-1:0] k;
        logic          last;
    } walk_step_t;

endpackage : fbt3_pkg
`default_nettype wire

### rtl/fbt3_walk.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fbt3_walk - next node of a three-axis fenwick walk
// upward walk (update) or downward walk (prefix), innermost axis k
// ---------------------------------------------------------------------------
module fbt3_walk (
    input  logic                    up,
    input  logic [fbt3_pkg::CW-1:0] n,
    input  logic [fbt3_pkg::CW-1:0] cur_i,
    input  logic [fbt3_pkg::CW-1:0] cur_j,
    input  logic [fbt3_pkg::CW-1:0] cur_k,
    input  logic [fbt3_pkg::CW-1:0] org_j,
    input  logic [fbt3_pkg::CW-1:0] org_k,
    output fbt3_pkg::walk_step_t    step
);

    function automatic logic [fbt3_pkg::CW-1:0] low_bit(input logic [fbt3_pkg::CW-1:0] v);
        return v & (~v + fbt3_pkg::CW'(1));
    endfunction

    logic [fbt3_pkg::CW-1:0] step_i;
    logic [fbt3_pkg::CW-1:0] step_j;
    logic [fbt3_pkg::CW-1:0] step_k;
    logic                    wrap_i;
    logic                    wrap_j;
    logic                    wrap_k;

    always_comb
    begin
        step_i = up ? (cur_i + low_bit(cur_i)) : (cur_i - low_bit(cur_i));
        step_j = up ? (cur_j + low_bit(cur_j)) : (cur_j - low_bit(cur_j));
        step_k = up ? (cur_k + low_bit(cur_k)) : (cur_k - low_bit(cur_k));
        wrap_i = up ? (step_i > n) : (step_i == '0);
        wrap_j = up ? (step_j > n) : (step_j == '0);
        wrap_k = up ? (step_k > n) : (step_k == '0);

        step.i    = cur_i;
        step.j    = cur_j;
        step.k    = step_k;
        step.last = 1'b0;
        if (wrap_k)
        begin
            step.k = org_k;
            step.j = step_j;
            if (wrap_j)
            begin
                step.j    = org_j;
                step.i    = step_i;
                step.last = wrap_i;
            end
        end
    end

endmodule : fbt3_walk
`default_nettype wire

### rtl/fenwick_3d_point_set_box_sum_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fenwick_3d_point_set_box_sum_top - 3d binary indexed tree, point set / box sum
// set replaces a point value, query sums a box by eight prefix walks
// ---------------------------------------------------------------------------
// sequence: a set reads the old point value, writes the new one, then reads and
//   rewrites each node of the upward walk; an ignored set goes straight to finish;
//   a query reads each node of up to eight prefix walks (125 nodes at index 31)
// throughput: one item at a time, one node read or read-modify-write at a time
// reset: clearing pass over every cell of both memories with busy high; the
//   receiver cannot stall, a result is on the ports for one cycle
module fenwick_3d_point_set_box_sum_top #(
    parameter int SIDE = fbt3_pkg::SIDE_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [fbt3_pkg::IN_CW-1:0]          cfg_wdata,
    // command
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [fbt3_pkg::IN_CW-1:0]          x_low,
    input  logic [fbt3_pkg::IN_CW-1:0]          y_low,
    input  logic [fbt3_pkg::IN_CW-1:0]          z_low,
    input  logic [fbt3_pkg::IN_CW-1:0]          x_high,
    input  logic [fbt3_pkg::IN_CW-1:0]          y_high,
    input  logic [fbt3_pkg::IN_CW-1:0]          z_high,
    input  logic signed [fbt3_pkg::VAL_W-1:0]   new_value,
    // result
    output logic                                done,
    output logic signed [fbt3_pkg::SUM_W-1:0]   box_sum,
    output logic signed [fbt3_pkg::SUM_W-1:0]   running_total
);

    localparam int CW    = fbt3_pkg::CW;
    localparam int VAL_W = fbt3_pkg::VAL_W;
    localparam int SUM_W = fbt3_pkg::SUM_W;
    // each axis index gets its own bit field of the cell address
    localparam int IW    = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int AW    = 3 * IW;
    localparam int DEPTH = 1 << AW;

    // cell address of a 1-based point known to lie inside the cube
    function automatic logic [AW-1:0] cell_addr(
        input logic [CW-1:0] ci,
        input logic [CW-1:0] cj,
        input logic [CW-1:0] ck
    );
        logic [CW+IW-1:0] ti;
        logic [CW+IW-1:0] tj;
        logic [CW+IW-1:0] tk;
        ti = (CW+IW)'(ci) - (CW+IW)'(1);
        tj = (CW+IW)'(cj) - (CW+IW)'(1);
        tk = (CW+IW)'(ck) - (CW+IW)'(1);
        return {ti[IW-1:0], tj[IW-1:0], tk[IW-1:0]};
    endfunction

    // clamp a coordinate to the cube side
    function automatic logic [CW-1:0] clamp_hi(
        input logic [CW-1:0] c,
        input logic [CW-1:0] lim
    );
        return (c > lim) ? lim : c;
    endfunction

    // ---------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------
    fbt3_pkg::state_t            state_reg, state_next;
    logic [fbt3_pkg::IN_CW-1:0]  side_reg;
    logic [AW-1:0]               clr_reg, clr_next;
    logic                        op_reg, op_next;
    logic [CW-1:0]               i_reg, i_next;
    logic [CW-1:0]               j_reg, j_next;
    logic [CW-1:0]               k_reg, k_next;
    logic [CW-1:0]               org_x_reg, org_x_next;   // set point / prefix origin
    logic [CW-1:0]               org_y_reg, org_y_next;
    logic [CW-1:0]               org_z_reg, org_z_next;
    logic [CW-1:0]               x1_reg, x1_next;         // box corners after clamping
    logic [CW-1:0]               y1_reg, y1_next;
    logic [CW-1:0]               z1_reg, z1_next;
    logic [CW-1:0]               x2_reg, x2_next;
    logic [CW-1:0]               y2_reg, y2_next;
    logic [CW-1:0]               z2_reg, z2_next;
    logic [2:0]                  pfx_reg, pfx_next;       // prefix number, bit set = low corner
    logic [VAL_W-1:0]            nv_reg, nv_next;
    logic [SUM_W-1:0]            delta_reg, delta_next;
    logic [SUM_W-1:0]            acc_reg, acc_next;
    logic [SUM_W-1:0]            total_reg, total_next;
    logic                        done_reg, done_next;

    // memories
    logic [SUM_W-1:0]            tree_mem  [DEPTH];
    logic [VAL_W-1:0]            point_mem [DEPTH];
    logic [SUM_W-1:0]            tree_rdata;
    logic [VAL_W-1:0]            point_rdata;
    logic                        tree_we;
    logic                        point_we;
    logic [AW-1:0]               tree_addr;
    logic [AW-1:0]               point_addr;
    logic [SUM_W-1:0]            tree_wdata;
    logic [VAL_W-1:0]            point_wdata;

    // shared 64-bit add / subtract unit
    logic [SUM_W-1:0]            add_a;
    logic [SUM_W-1:0]            add_b;
    logic                        add_sub;
    logic [SUM_W-1:0]            add_y;

    // misc
    logic [CW-1:0]               n_side;
    logic                        accept;
    logic                        in_cube;
    logic                        clr_last;
    logic                        pfx_empty;
    logic                        pfx_sign;
    logic [CW-1:0]               pfx_x;
    logic [CW-1:0]               pfx_y;
    logic [CW-1:0]               pfx_z;
    logic [CW-1:0]               xl_c;
    logic [CW-1:0]               yl_c;
    logic [CW-1:0]               zl_c;
    logic [CW-1:0]               xl_m1;
    logic [CW-1:0]               yl_m1;
    logic [CW-1:0]               zl_m1;
    fbt3_pkg::walk_step_t        walk;

    // ---------------------------------------------------------------------
    // side in use, capped at the built cube side
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= fbt3_pkg::SIDE_RESET;
        else if (cfg_we)
            side_reg <= cfg_wdata;
    end

    assign n_side = (int'(side_reg) > SIDE) ? CW'(SIDE) : CW'(side_reg);

    // ---------------------------------------------------------------------
    // input decode
    // ---------------------------------------------------------------------
    assign accept = start && (state_reg == fbt3_pkg::ST_IDLE);
    assign xl_c   = CW'(x_low);
    assign yl_c   = CW'(y_low);
    assign zl_c   = CW'(z_low);
    assign xl_m1  = xl_c - CW'(1);
    assign yl_m1  = yl_c - CW'(1);
    assign zl_m1  = zl_c - CW'(1);
    assign in_cube = (xl_c != '0) && (xl_c <= n_side)
                  && (yl_c != '0) && (yl_c <= n_side)
                  && (zl_c != '0) && (zl_c <= n_side);

    // prefix corner: each set bit of the prefix number picks the low corner,
    // an odd count of low picks subtracts
    assign pfx_x     = pfx_reg[2] ? x1_reg : x2_reg;
    assign pfx_y     = pfx_reg[1] ? y1_reg : y2_reg;
    assign pfx_z     = pfx_reg[0] ? z1_reg : z2_reg;
    assign pfx_empty = (pfx_x == '0) || (pfx_y == '0) || (pfx_z == '0);
    assign pfx_sign  = ^pfx_reg;
    assign clr_last  = &clr_reg;

    // ---------------------------------------------------------------------
    // walk step: upward for a set, downward for a prefix
    // ---------------------------------------------------------------------
    fbt3_walk u_walk (
        .up    (op_reg == fbt3_pkg::OP_SET),
        .n     (n_side),
        .cur_i (i_reg),
        .cur_j (j_reg),
        .cur_k (k_reg),
        .org_j (org_y_reg),
        .org_k (org_z_reg),
        .step  (walk)
    );

    assign add_y = add_a + (add_sub ? ~add_b : add_b) + SUM_W'(add_sub);

    // ---------------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fbt3_pkg::ST_CLEAR:
            begin
                if (clr_last)
                    state_next = fbt3_pkg::ST_IDLE;
            end
            fbt3_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == fbt3_pkg::OP_QUERY)
                        state_next = fbt3_pkg::ST_PFX_START;
                    else if (in_cube)
                        state_next = fbt3_pkg::ST_SET_RD;
                    else
                        state_next = fbt3_pkg::ST_FINISH;
                end
            end
            fbt3_pkg::ST_SET_RD:
                state_next = fbt3_pkg::ST_SET_DELTA;
            fbt3_pkg::ST_SET_DELTA:
                state_next = fbt3_pkg::ST_NODE_RD;
            fbt3_pkg::ST_PFX_START:
            begin
                if (!pfx_empty)
                    state_next = fbt3_pkg::ST_NODE_RD;
                else if (&pfx_reg)
                    state_next = fbt3_pkg::ST_FINISH;
            end
            fbt3_pkg::ST_NODE_RD:
                state_next = fbt3_pkg::ST_NODE_UPD;
            fbt3_pkg::ST_NODE_UPD:
            begin
                if (!walk.last)
                    state_next = fbt3_pkg::ST_NODE_RD;
                else if ((op_reg == fbt3_pkg::OP_SET) || (&pfx_reg))
                    state_next = fbt3_pkg::ST_FINISH;
                else
                    state_next = fbt3_pkg::ST_PFX_START;
            end
            fbt3_pkg::ST_FINISH:
                state_next = fbt3_pkg::ST_IDLE;
            default:
                state_next = fbt3_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // sequencer: datapath and memory control
    // ---------------------------------------------------------------------
    always_comb
    begin
        clr_next    = clr_reg;
        op_next     = op_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        org_x_next  = org_x_reg;
        org_y_next  = org_y_reg;
        org_z_next  = org_z_reg;
        x1_next     = x1_reg;
        y1_next     = y1_reg;
        z1_next     = z1_reg;
        x2_next     = x2_reg;
        y2_next     = y2_reg;
        z2_next     = z2_reg;
        pfx_next    = pfx_reg;
        nv_next     = nv_reg;
        delta_next  = delta_reg;
        acc_next    = acc_reg;
        total_next  = total_reg;
        done_next   = 1'b0;

        tree_we     = 1'b0;
        point_we    = 1'b0;
        tree_addr   = cell_addr(i_reg, j_reg, k_reg);
        point_addr  = cell_addr(org_x_reg, org_y_reg, org_z_reg);
        tree_wdata  = add_y;
        point_wdata = nv_reg;

        add_a   = acc_reg;
        add_b   = tree_rdata;
        add_sub = 1'b0;

        unique case (state_reg)
            fbt3_pkg::ST_CLEAR:
            begin
                tree_we     = 1'b1;
                point_we    = 1'b1;
                tree_addr   = clr_reg;
                point_addr  = clr_reg;
                tree_wdata  = '0;
                point_wdata = '0;
                clr_next    = clr_reg + AW'(1);
            end
            fbt3_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op;
                    acc_next   = '0;
                    pfx_next   = '0;
                    nv_next    = new_value;
                    i_next     = xl_c;
                    j_next     = yl_c;
                    k_next     = zl_c;
                    org_x_next = xl_c;
                    org_y_next = yl_c;
                    org_z_next = zl_c;
                    x2_next    = clamp_hi(CW'(x_high), n_side);
                    y2_next    = clamp_hi(CW'(y_high), n_side);
                    z2_next    = clamp_hi(CW'(z_high), n_side);
                    // a low corner of zero gives an empty "low minus one" prefix
                    x1_next    = (xl_c == '0) ? '0 : clamp_hi(xl_m1, n_side);
                    y1_next    = (yl_c == '0) ? '0 : clamp_hi(yl_m1, n_side);
                    z1_next    = (zl_c == '0) ? '0 : clamp_hi(zl_m1, n_side);
                end
            end
            fbt3_pkg::ST_SET_RD:
            begin
                // point read issued at the set point, data next cycle
            end
            fbt3_pkg::ST_SET_DELTA:
            begin
                add_a      = {{(SUM_W-VAL_W){nv_reg[VAL_W-1]}}, nv_reg};
                add_b      = {{(SUM_W-VAL_W){point_rdata[VAL_W-1]}}, point_rdata};
                add_sub    = 1'b1;
                delta_next = add_y;
                point_we   = 1'b1;
            end
            fbt3_pkg::ST_PFX_START:
            begin
                i_next     = pfx_x;
                j_next     = pfx_y;
                k_next     = pfx_z;
                org_x_next = pfx_x;
                org_y_next = pfx_y;
                org_z_next = pfx_z;
                if (pfx_empty && !(&pfx_reg))
                    pfx_next = pfx_reg + 3'd1;
            end
            fbt3_pkg::ST_NODE_RD:
            begin
                // tree read issued at the current walk node
            end
            fbt3_pkg::ST_NODE_UPD:
            begin
                if (op_reg == fbt3_pkg::OP_SET)
                begin
                    add_a   = tree_rdata;
                    add_b   = delta_reg;
                    tree_we = 1'b1;
                end
                else
                begin
                    add_sub  = pfx_sign;
                    acc_next = add_y;
                    if (walk.last && !(&pfx_reg))
                        pfx_next = pfx_reg + 3'd1;
                end
                i_next = walk.i;
                j_next = walk.j;
                k_next = walk.k;
            end
            fbt3_pkg::ST_FINISH:
            begin
                // box sum is zero on a set, so the total picks up nothing
                add_a      = total_reg;
                add_b      = acc_reg;
                total_next = add_y;
                done_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbt3_pkg::ST_CLEAR;
            clr_reg   <= '0;
            op_reg    <= fbt3_pkg::OP_SET;
            pfx_reg   <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            op_reg    <= op_next;
            pfx_reg   <= pfx_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    // ---------------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        org_x_reg <= org_x_next;
        org_y_reg <= org_y_next;
        org_z_reg <= org_z_next;
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        z1_reg    <= z1_next;
        x2_reg    <= x2_next;
        y2_reg    <= y2_next;
        z2_reg    <= z2_next;
        nv_reg    <= nv_next;
        delta_reg <= delta_next;
        acc_reg   <= acc_next;
    end

    // ---------------------------------------------------------------------
    // tree node and point value memories, one port each, registered read
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (tree_we)
            tree_mem[tree_addr] <= tree_wdata;
        tree_rdata <= tree_mem[tree_addr];
    end

    always_ff @(posedge clk)
    begin
        if (point_we)
            point_mem[point_addr] <= point_wdata;
        point_rdata <= point_mem[point_addr];
    end

    // ---------------------------------------------------------------------
    // outputs: result held in acc / total, shown for the one done cycle
    // ---------------------------------------------------------------------
    assign busy          = (state_reg != fbt3_pkg::ST_IDLE);
    assign done          = done_reg;
    assign box_sum       = acc_reg;
    assign running_total = total_reg;

endmodule : fenwick_3d_point_set_box_sum_top
`default_nettype wire

### rtl/fbt3_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fbt3_checker - port-level checks on the box sum block
// command and result timing seen from the top level ports
// ---------------------------------------------------------------------------
module fbt3_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // item accepted while not busy keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after item accept");

    // a result strobe is a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // a result appears only after the block was working
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

endmodule : fbt3_checker

bind fenwick_3d_point_set_box_sum_top fbt3_checker u_fbt3_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - self-checking bench for the 3d binary indexed tree block
// drives point-set and box-query items through the start/busy handshake,
// predicts every box sum and running total with a private copy of the tree,
// and checks each done strobe against the oldest expected item
// ---------------------------------------------------------------------------
module tb;

    localparam int IN_CW  = fbt3_pkg::IN_CW;
    localparam int VAL_W  = fbt3_pkg::VAL_W;
    localparam int SUM_W  = fbt3_pkg::SUM_W;
    localparam int CUBE   = fbt3_pkg::SIDE_DEFAULT;
    localparam int CELLS  = CUBE * CUBE * CUBE;
    localparam int NO_GAP = 0;
    localparam int GAPS   = 1;

    // one command item as it goes into the block
    typedef struct {
        logic                    op;
        logic [IN_CW-1:0]        x_low;
        logic [IN_CW-1:0]        y_low;
        logic [IN_CW-1:0]        z_low;
        logic [IN_CW-1:0]        x_high;
        logic [IN_CW-1:0]        y_high;
        logic [IN_CW-1:0]        z_high;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    // one result item as it should come out
    typedef struct {
        longint box;
        longint total;
    } sums_t;

    // -----------------------------------------------------------------------
    // box sum scoreboard: private tree, point store and accumulator
    // -----------------------------------------------------------------------
    class box_sum_board;
        longint      tree_nodes [CELLS];
        int          point_vals [CELLS];
        longint      grand_total;
        int          side;
        sums_t       pending_sums [$];
        int          errors;
        int          n_sets;
        int          n_ignored;
        int          n_queries;
        int          n_checked;

        function new();
            grand_total = 0;
            side        = int'(fbt3_pkg::SIDE_RESET);
            errors      = 0;
            n_sets      = 0;
            n_ignored   = 0;
            n_queries   = 0;
            n_checked   = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void set_side(input logic [IN_CW-1:0] v);
            side = int'(v);
        endfunction

        function int node_at(input int x, input int y, input int z);
            return ((x - 1) * CUBE + (y - 1)) * CUBE + (z - 1);
        endfunction

        // upward walk, bounded by the side in use at the time of the set
        function void spread_delta(input int x, input int y, input int z,
                                   input int n, input longint delta);
            for (int i = x; i >= 1 && i <= n; i += i & -i)
                for (int j = y; j >= 1 && j <= n; j += j & -j)
                    for (int k = z; k >= 1 && k <= n; k += k & -k)
                        tree_nodes[node_at(i, j, k)] += delta;
        endfunction

        function longint prefix_sum(input int x, input int y, input int z);
            longint s;
            s = 0;
            for (int i = x; i > 0; i -= i & -i)
                for (int j = y; j > 0; j -= j & -j)
                    for (int k = z; k > 0; k -= k & -k)
                        s += tree_nodes[node_at(i, j, k)];
            return s;
        endfunction

        function int clamp_top(input int c, input int n);
            return (c > n) ? n : c;
        endfunction

        function int clamp_under(input int c, input int n);
            return (c == 0) ? 0 : clamp_top(c - 1, n);
        endfunction

        function void note_item(input cmd_t c);
            sums_t  r;
            int     n;
            int     idx;
            int     xa, ya, za, xb, yb, zb;
            longint delta;
            n     = (side > CUBE) ? CUBE : side;
            r.box = 0;
            if (c.op == fbt3_pkg::OP_SET)
            begin
                if (c.x_low >= 1 && c.x_low <= n && c.y_low >= 1 && c.y_low <= n &&
                    c.z_low >= 1 && c.z_low <= n)
                begin
                    idx   = node_at(c.x_low, c.y_low, c.z_low);
                    delta = longint'(c.value) - longint'(point_vals[idx]);
                    spread_delta(c.x_low, c.y_low, c.z_low, n, delta);
                    point_vals[idx] = c.value;
                    n_sets++;
                end
                else
                begin
                    n_ignored++;
                end
            end
            else
            begin
                xb = clamp_top(c.x_high, n);
                yb = clamp_top(c.y_high, n);
                zb = clamp_top(c.z_high, n);
                xa = clamp_under(c.x_low, n);
                ya = clamp_under(c.y_low, n);
                za = clamp_under(c.z_low, n);
                r.box = prefix_sum(xb, yb, zb)
                      - prefix_sum(xb, yb, za) - prefix_sum(xa, yb, zb)
                      - prefix_sum(xb, ya, zb)
                      + prefix_sum(xa, ya, zb) + prefix_sum(xb, ya, za)
                      + prefix_sum(xa, yb, za)
                      - prefix_sum(xa, ya, za);
                grand_total += r.box;
                n_queries++;
            end
            r.total = grand_total;
            pending_sums.push_back(r);
        endfunction

        function int outstanding();
            return pending_sums.size();
        endfunction

        task check_result(input logic [SUM_W-1:0] box, input logic [SUM_W-1:0] total);
            sums_t want;
            if (pending_sums.size() == 0)
            begin
                report($sformatf("result with nothing expected: box %0d total %0d",
                                 $signed(box), $signed(total)));
            end
            else
            begin
                want = pending_sums.pop_front();
                n_checked++;
                if (box !== want.box)
                    report($sformatf("box_sum %0d, want %0d", $signed(box), want.box));
                if (total !== want.total)
                    report($sformatf("running_total %0d, want %0d",
                                     $signed(total), want.total));
            end
        endtask
    endclass

    // -----------------------------------------------------------------------
    // clock, reset and block ports (every input known from time zero)
    // -----------------------------------------------------------------------
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [IN_CW-1:0]        cfg_wdata = '0;
    logic                    start     = 1'b0;
    logic                    busy;
    logic                    op        = fbt3_pkg::OP_SET;
    logic [IN_CW-1:0]        x_low     = '0;
    logic [IN_CW-1:0]        y_low     = '0;
    logic [IN_CW-1:0]        z_low     = '0;
    logic [IN_CW-1:0]        x_high    = '0;
    logic [IN_CW-1:0]        y_high    = '0;
    logic [IN_CW-1:0]        z_high    = '0;
    logic signed [VAL_W-1:0] new_value = '0;
    logic                    done;
    logic signed [SUM_W-1:0] box_sum;
    logic signed [SUM_W-1:0] running_total;

    box_sum_board board = new();

    initial
    begin
        forever #5 clk = ~clk;
    end

    fenwick_3d_point_set_box_sum_top #(
        .SIDE (CUBE)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .x_low         (x_low),
        .y_low         (y_low),
        .z_low         (z_low),
        .x_high        (x_high),
        .y_high        (y_high),
        .z_high        (z_high),
        .new_value     (new_value),
        .done          (done),
        .box_sum       (box_sum),
        .running_total (running_total)
    );

    // result monitor: done is a one-cycle strobe, the bench cannot stall it,
    // so every edge with done high is one result item
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            board.check_result(box_sum, running_total);
    end

    // -----------------------------------------------------------------------
    // item builders
    // -----------------------------------------------------------------------
    function automatic cmd_t set_cmd(input int x, input int y, input int z,
                                     input logic [VAL_W-1:0] v);
        cmd_t c;
        c        = '{default: '0};
        c.op     = fbt3_pkg::OP_SET;
        c.x_low  = IN_CW'(x);
        c.y_low  = IN_CW'(y);
        c.z_low  = IN_CW'(z);
        // the box corner fields are don't-care on a set, fill them anyway
        c.x_high = IN_CW'($urandom);
        c.y_high = IN_CW'($urandom);
        c.z_high = IN_CW'($urandom);
        c.value  = v;
        return c;
    endfunction

    function automatic cmd_t query_cmd(input int xa, input int ya, input int za,
                                       input int xb, input int yb, input int zb);
        cmd_t c;
        c        = '{default: '0};
        c.op     = fbt3_pkg::OP_QUERY;
        c.x_low  = IN_CW'(xa);
        c.y_low  = IN_CW'(ya);
        c.z_low  = IN_CW'(za);
        c.x_high = IN_CW'(xb);
        c.y_high = IN_CW'(yb);
        c.z_high = IN_CW'(zb);
        // value is ignored on a query, keep it noisy
        c.value  = $urandom;
        return c;
    endfunction

    // a coordinate for side n: mostly inside the cube, sometimes anywhere
    function automatic int draw_coord(input int n);
        if (n == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, (1 << IN_CW) - 1);
        return $urandom_range(1, n);
    endfunction

    // a span along one axis: usually ordered, now and then inverted
    function automatic void draw_span(input int n, output int lo, output int hi);
        int a;
        int b;
        a = draw_coord(n);
        b = draw_coord(n);
        if (a > b && $urandom_range(0, 9) != 0)
        begin
            lo = b;
            hi = a;
        end
        else
        begin
            lo = a;
            hi = b;
        end
    endfunction

    function automatic logic [VAL_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // drivers
    // -----------------------------------------------------------------------

    // present one item and hold it until the block takes it (start high,
    // busy low at an edge); then maybe idle for a random gap with start low
    task automatic issue(input cmd_t c, input int idle_mode);
        int unsigned gap;
        gap       = (idle_mode == GAPS) ? $urandom_range(0, 5) : 0;
        start     <= 1'b1;
        op        <= c.op;
        x_low     <= c.x_low;
        y_low     <= c.y_low;
        z_low     <= c.z_low;
        x_high    <= c.x_high;
        y_high    <= c.y_high;
        z_high    <= c.z_high;
        new_value <= c.value;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        board.note_item(c);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait until every expected result is back and the
    // block has dropped busy
    task automatic drain();
        start <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // side register write, only ever done with the block idle
    task automatic write_side(input int v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= IN_CW'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_side(IN_CW'(v));
    endtask

    // random phase: a mix of sets and box queries under one side setting,
    // idling on or off at the start, chosen per phase and flipped now and then
    task automatic run_phase(input int side, input int count);
        cmd_t c;
        int   n;
        int   xa, ya, za, xb, yb, zb;
        int   idle_mode;
        n         = (side > CUBE) ? CUBE : side;
        idle_mode = $urandom_range(0, 3) == 0 ? NO_GAP : GAPS;
        write_side(side);
        for (int it = 0; it < count; it++)
        begin
            // flip idling now and then so bursts and gaps both show up
            if ($urandom_range(0, 31) == 0)
                idle_mode = (idle_mode == GAPS) ? NO_GAP : GAPS;
            if ($urandom_range(0, 1) == 0)
            begin
                c = set_cmd(draw_coord(n), draw_coord(n), draw_coord(n), draw_value());
            end
            else
            begin
                draw_span(n, xa, xb);
                draw_span(n, ya, yb);
                draw_span(n, za, zb);
                c = query_cmd(xa, ya, za, xb, yb, zb);
            end
            issue(c, idle_mode);
        end
    endtask

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full side, corner points, value extremes, replace,
        // sets outside the cube, clamped and inverted boxes
        write_side(CUBE);
        issue(set_cmd(1, 1, 1, 32'h7fff_ffff), GAPS);
        issue(set_cmd(CUBE, CUBE, CUBE, 32'h8000_0000), GAPS);
        issue(set_cmd(CUBE, 1, 17, 32'hffff_ffff), NO_GAP);
        issue(set_cmd(1, CUBE, 5, 32'd12345), NO_GAP);
        issue(query_cmd(1, 1, 1, CUBE, CUBE, CUBE), GAPS);
        // replace an existing point with a new value
        issue(set_cmd(1, 1, 1, -32'sd5), GAPS);
        issue(set_cmd(CUBE, CUBE, CUBE, 32'h8000_0000), NO_GAP);
        // set points outside the cube are dropped
        issue(set_cmd(0, 5, 5, 32'd99), GAPS);
        issue(set_cmd(5, 0, 5, 32'd99), NO_GAP);
        issue(set_cmd(5, 5, 0, 32'd99), NO_GAP);
        issue(set_cmd(CUBE + 1, 1, 1, 32'd77), GAPS);
        issue(set_cmd(63, 63, 63, 32'hffff_ffff), GAPS);
        issue(query_cmd(1, 1, 1, CUBE, CUBE, CUBE), NO_GAP);
        issue(query_cmd(1, 1, 1, 1, 1, 1), GAPS);
        issue(query_cmd(CUBE, CUBE, CUBE, CUBE, CUBE, CUBE), GAPS);
        // zero low corner and high corner past the cube both clamp
        issue(query_cmd(0, 0, 0, 63, 63, 63), NO_GAP);
        issue(query_cmd(0, 0, 0, 0, 0, 0), GAPS);
        // inverted boxes go through inclusion-exclusion unchecked
        issue(query_cmd(20, 20, 20, 3, 3, 3), GAPS);
        issue(query_cmd(CUBE, 1, 17, CUBE - 1, 1, 17), NO_GAP);
        issue(query_cmd(1, CUBE, 5, 1, CUBE, 5), GAPS);

        // random phases across side settings: both extremes, a size past
        // the cube (acts as full), and zero (everything drops to nothing)
        run_phase(32, 120);
        run_phase(1, 40);
        run_phase(7, 100);
        run_phase(63, 100);
        run_phase(0, 20);
        run_phase(16, 100);
        run_phase(33, 60);
        run_phase(32, 60);

        // everything in, let any stray strobe show up
        drain();
        repeat (50) @(posedge clk);

        $display("covered %0d applied sets, %0d sets outside the cube, %0d box queries",
                 board.n_sets, board.n_ignored, board.n_queries);
        $display("side settings 32 1 7 63 0 16 33 32, %0d results checked, %0d errors",
                 board.n_checked, board.errors);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run limit: room for the worst-case queries and the clearing pass
    initial
    begin
        #50_000_000;
        $display("timeout with %0d results outstanding", board.outstanding());
        $display("FAILURE");
        $finish;
    end

endmodule
